@@ rtl/core/three_axis_packet_framer_crc8_unit_defines.svh @@
// Assertion macros shared by the three-axis packet framer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef THREE_AXIS_PACKET_FRAMER_CRC8_UNIT_DEFINES_SVH
`define THREE_AXIS_PACKET_FRAMER_CRC8_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TAPF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TAPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tapf_pkg.sv @@
// Package for the three-axis packet framer: request types, frame constants
// and the CRC-8 byte update function. Depends on nothing.
`timescale 1ns / 1ps

package tapf_pkg;

    localparam int PAYLOAD_BYTES = 12;
    localparam int FRAME_BYTES   = PAYLOAD_BYTES + 3;
    localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;

    localparam logic [3:0] POS_SYNC0         = 4'd0;
    localparam logic [3:0] POS_SYNC1         = 4'd1;
    localparam logic [3:0] POS_FIRST_PAYLOAD = 4'd2;
    localparam logic [3:0] POS_LAST_PAYLOAD  = 4'd13;
    localparam logic [3:0] POS_CRC           = 4'd14;

    localparam logic [1:0] CFG_FIRST_SYNC  = 2'd0;
    localparam logic [1:0] CFG_SECOND_SYNC = 2'd1;

    localparam logic [7:0] FIRST_SYNC_RESET  = 8'd170;
    localparam logic [7:0] SECOND_SYNC_RESET = 8'd85;

    localparam logic [22:0] CLAMP_Q16  = 23'd6553600;
    localparam logic [13:0] SCALE      = 14'd10000;
    localparam logic [36:0] ROUND_HALF = 37'd32768;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic signed [31:0] z_value;
    } t_in_req;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [3:0] byte_position;
        logic       last_of_frame;
    } t_out_req;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/tapf_axis_encoder.sv @@
// Axis encoder: clamps a Q15.16 value to +/-100.0 and scales it by 10000
// with rounding half away from zero. Depends on tapf_pkg.
`timescale 1ns / 1ps

module tapf_axis_encoder
    import tapf_pkg::*;
(
    input  logic signed [31:0] i_value,
    output logic        [31:0] o_word
);

    logic        w_neg;
    logic [32:0] w_ext;
    logic [32:0] w_mag;
    logic [22:0] w_clamped;
    logic [36:0] w_scaled;
    logic [20:0] w_q;
    logic [31:0] w_q_ext;

    assign w_neg     = i_value[31];
    assign w_ext     = {i_value[31], i_value};
    assign w_mag     = w_neg ? (33'd0 - w_ext) : w_ext;
    assign w_clamped = (w_mag > {10'd0, CLAMP_Q16}) ? CLAMP_Q16 : w_mag[22:0];
    assign w_scaled  = ({14'd0, w_clamped} * {23'd0, SCALE}) + ROUND_HALF;
    assign w_q       = w_scaled[36:16];
    assign w_q_ext   = {11'd0, w_q};
    assign o_word    = w_neg ? (32'd0 - w_q_ext) : w_q_ext;

endmodule

@@ rtl/core/three_axis_packet_framer_crc8_unit.sv @@
// Top level of the three-axis packet framer with CRC-8/SMBUS.
// Depends on tapf_pkg, tapf_axis_encoder and the assertion macro header.
`timescale 1ns / 1ps
`include "three_axis_packet_framer_crc8_unit_defines.svh"

// Each accepted request of three Q15.16 axis values becomes a 15-byte frame
// sent one byte per output request: two sync bytes, the three scaled axis
// integers as little-endian bytes, and a CRC-8/SMBUS over the 12 payload
// bytes. A request is held in the input register, is encoded as it loads
// into the byte serializer, and its first byte appears the cycle after that.
// The serializer emits one byte per cycle while the output is ready; a
// waiting request starts its frame right after the last byte of the one
// before, and one further request can be held in the input register while
// a frame is still going out. The CRC takes in each payload byte as it leaves.
// The sync bytes come from the configuration registers (reset 0xAA, 0x55).

module three_axis_packet_framer_crc8_unit
    import tapf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_req    i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_req   o_out_req
);

    logic [7:0] r_sync0;
    logic [7:0] r_sync1;

    logic       r_in_vld;
    t_in_req    r_in;

    logic                    r_busy;
    logic [3:0]              r_pos;
    logic [7:0]              r_crc;
    logic [PAYLOAD_BITS-1:0] r_payload;

    logic                    n_busy;
    logic [3:0]              n_pos;
    logic [7:0]              n_crc;

    logic [31:0] w_x_word;
    logic [31:0] w_y_word;
    logic [31:0] w_z_word;
    logic        w_in_fire;
    logic        w_out_fire;
    logic        w_last;
    logic        w_load;
    logic [3:0]  w_off;
    logic [7:0]  w_byte;

    tapf_axis_encoder u_enc_x (.i_value(r_in.x_value), .o_word(w_x_word));
    tapf_axis_encoder u_enc_y (.i_value(r_in.y_value), .o_word(w_y_word));
    tapf_axis_encoder u_enc_z (.i_value(r_in.z_value), .o_word(w_z_word));

    assign w_last     = (r_pos == POS_CRC);
    assign w_out_fire = r_busy && i_out_ready;
    assign w_load     = r_in_vld && (!r_busy || (w_out_fire && w_last));
    assign o_in_ready = !r_in_vld || w_load;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign w_off = r_pos - POS_FIRST_PAYLOAD;

    always_comb begin
        case (r_pos)
            POS_SYNC0: w_byte = r_sync0;
            POS_SYNC1: w_byte = r_sync1;
            POS_CRC:   w_byte = r_crc;
            default:   w_byte = r_payload[{w_off, 3'b000} +: 8];
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        n_crc  = r_crc;
        if (w_load) begin
            n_busy = 1'b1;
            n_pos  = POS_SYNC0;
            n_crc  = CRC_INIT;
        end else if (w_out_fire) begin
            if (w_last) begin
                n_busy = 1'b0;
                n_pos  = POS_SYNC0;
            end else begin
                n_pos = r_pos + 4'd1;
            end
            if (r_pos inside {[POS_FIRST_PAYLOAD:POS_LAST_PAYLOAD]}) begin
                n_crc = crc8_byte(r_crc, w_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync0 <= FIRST_SYNC_RESET;
            r_sync1 <= SECOND_SYNC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_SYNC:  r_sync0 <= i_cfg_data;
                CFG_SECOND_SYNC: r_sync1 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_busy   <= 1'b0;
            r_pos    <= POS_SYNC0;
            r_crc    <= CRC_INIT;
        end else begin
            r_in_vld <= w_in_fire || (r_in_vld && !w_load);
            r_busy   <= n_busy;
            r_pos    <= n_pos;
            r_crc    <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in <= i_in_req;
        end
        if (w_load) begin
            r_payload <= {w_z_word, w_y_word, w_x_word};
        end
    end

    assign o_out_valid             = r_busy;
    assign o_out_req.frame_byte    = w_byte;
    assign o_out_req.byte_position = r_pos;
    assign o_out_req.last_of_frame = w_last;

    `TAPF_ASSERT_NEXT(a_pos_advance, i_clk, i_rst_n, w_out_fire && !w_last, r_pos == $past(r_pos) + 4'd1, "byte position did not advance")
    `TAPF_ASSERT_SAME(a_crc_start, i_clk, i_rst_n, r_busy && (r_pos == POS_FIRST_PAYLOAD), r_crc == CRC_INIT, "CRC not cleared at start of payload")
    `TAPF_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, w_out_fire && w_last && !r_in_vld, !o_out_valid, "output valid after frame end with no pending request")

endmodule
